/* src/cmps_pkg.sv */
package cmps_pkg;

  localparam int MAX_COLUMNS_DEF      = 1024;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int MASS_W   = 32;
  localparam int PHASE_W  = 16;
  localparam int TRIG_W   = 15;
  localparam int PROD_W   = 48;
  localparam int MAG_W    = 64;
  localparam int HALF_W   = 32;
  localparam int SQ_W     = 128;
  localparam int POWER_W  = 64;
  localparam int CFG_W    = 32;
  localparam int ADDR_W   = 3;

  localparam int QUAD_SHIFT   = 14;
  localparam int POWER_SHIFT  = 46;
  localparam int REG_IDX_BIT  = 2;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

  // register indexes
  localparam logic REG_PHASE_STEP = 1'b0;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TRIG_AMP    = 64'd32767;

  // sine of x (q30 radians) scaled to 32767, taylor series to x^9
  function automatic logic [TRIG_W-1:0] sine_from_x(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    r = (s * TRIG_AMP + (Q30_ONE >> 1)) >> 30;
    return r[TRIG_W-1:0];
  endfunction

endpackage

/* src/cmps_sine_lookup.sv */
module cmps_sine_lookup #(
  parameter int SINE_TABLE_DEPTH = cmps_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic [cmps_pkg::PHASE_W-1:0]       phase,
  output logic signed [cmps_pkg::TRIG_W:0]   value
);
  import cmps_pkg::*;

  localparam int TW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = QUAD_SHIFT + TW;

  logic [TRIG_W-1:0] sine_tab [SINE_TABLE_DEPTH+1];
  logic [1:0]        quad;
  logic [PW-1:0]     scaled;
  logic [TW-1:0]     j;
  logic [TW-1:0]     idx;
  logic [TRIG_W-1:0] mag;

  // quarter-wave table, endpoints included
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] X = (HALF_PI_Q30 * 64'(g)) / SINE_TABLE_DEPTH;
    assign sine_tab[g] = sine_from_x(X);
  end

  always_comb begin
    quad   = phase[PHASE_W-1 -: 2];
    scaled = PW'(phase[QUAD_SHIFT-1:0]) * PW'(SINE_TABLE_DEPTH);
    j      = scaled[PW-1:QUAD_SHIFT];
    idx    = quad[0] ? TW'(SINE_TABLE_DEPTH) - j : j;
    mag    = sine_tab[idx];
    value  = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

/* src/cmps_accum.sv */
module cmps_accum #(
  parameter int MAX_COLUMNS      = cmps_pkg::MAX_COLUMNS_DEF,
  parameter int SINE_TABLE_DEPTH = cmps_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int ACC_W            = cmps_pkg::PROD_W + $clog2(MAX_COLUMNS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cmps_pkg::PHASE_W-1:0]      phase_step,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cmps_pkg::MASS_W-1:0]       in_mass,
  input  logic                              in_last,
  output logic                              sum_valid,
  input  logic                              sum_ready,
  output logic signed [ACC_W-1:0]           sum_re,
  output logic signed [ACC_W-1:0]           sum_im
);
  import cmps_pkg::*;

  localparam int CW     = $clog2(MAX_COLUMNS + 1);
  localparam int PFULLW = MASS_W + TRIG_W + 2;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic               col_en;
  logic               in_acc;
  logic [PHASE_W-1:0] phase_cos;
  logic signed [TRIG_W:0] sin_val, cos_val;

  logic                   s1_valid_r, s1_last_r, s1_en_r;
  logic [MASS_W-1:0]      s1_mass_r;
  logic signed [TRIG_W:0] s1_sin_r, s1_cos_r;
  logic                   s1_free, s1_move;

  logic signed [PFULLW-1:0] prod_re_full, prod_im_full;
  logic                     s2_valid_r, s2_last_r, s2_en_r;
  logic signed [PROD_W-1:0] prod_re_r, prod_im_r;
  logic                     s2_free, s2_move;

  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] run_re, run_im;
  logic                    sum_valid_r;
  logic signed [ACC_W-1:0] sum_re_r, sum_im_r;
  logic                    sum_free;

  assign phase_cos = PHASE_W'(phase_r + QUARTER_TURN);

  cmps_sine_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin (
    .phase (phase_r),
    .value (sin_val)
  );

  cmps_sine_lookup #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos (
    .phase (phase_cos),
    .value (cos_val)
  );

  // bubble-collapsing flow control
  always_comb begin
    sum_free = !sum_valid_r || sum_ready;
    s2_move  = s2_valid_r && (!s2_last_r || sum_free);
    s2_free  = !s2_valid_r || s2_move;
    s1_move  = s1_valid_r && s2_free;
    s1_free  = !s1_valid_r || s1_move;
    in_ready = s1_free;
    in_acc   = in_valid && s1_free;
  end

  // run state advances in accept order
  always_comb begin
    col_en    = col_r < CW'(MAX_COLUMNS);
    phase_nxt = phase_r;
    col_nxt   = col_r;
    if (in_acc) begin
      if (in_last) begin
        phase_nxt = '0;
        col_nxt   = '0;
      end else if (col_en) begin
        phase_nxt = PHASE_W'(phase_r + phase_step);
        col_nxt   = CW'(col_r + 1'b1);
      end
    end
  end

  always_comb begin
    prod_re_full = $signed({1'b0, s1_mass_r}) * s1_cos_r;
    prod_im_full = $signed({1'b0, s1_mass_r}) * s1_sin_r;
    run_re = s2_en_r ? acc_re_r + ACC_W'(prod_re_r) : acc_re_r;
    run_im = s2_en_r ? acc_im_r + ACC_W'(prod_im_r) : acc_im_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      sum_valid_r <= 1'b0;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (sum_free) begin
        sum_valid_r <= s2_move && s2_last_r;
      end
      if (s2_move) begin
        acc_re_r <= s2_last_r ? '0 : run_re;
        acc_im_r <= s2_last_r ? '0 : run_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r <= in_last;
      s1_en_r   <= col_en;
      s1_mass_r <= in_mass;
      s1_sin_r  <= sin_val;
      s1_cos_r  <= cos_val;
    end
    if (s1_move) begin
      s2_last_r <= s1_last_r;
      s2_en_r   <= s1_en_r;
      prod_re_r <= PROD_W'(prod_re_full);
      prod_im_r <= PROD_W'(prod_im_full);
    end
    if (s2_move && s2_last_r) begin
      sum_re_r <= run_re;
      sum_im_r <= run_im;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum_re    = sum_re_r;
  assign sum_im    = sum_im_r;

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (col_r == '0 && phase_r == '0))
    else $error("run state not cleared after last word");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_move && s2_last_r) |=> (acc_re_r == '0 && acc_im_r == '0))
    else $error("accumulators not cleared at end of run");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(MAX_COLUMNS))
    else $error("column count past limit");

endmodule

/* src/cmps_power.sv */
module cmps_power #(
  parameter int ACC_W = cmps_pkg::PROD_W + $clog2(cmps_pkg::MAX_COLUMNS_DEF + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ACC_W-1:0]       sum_re,
  input  logic signed [ACC_W-1:0]       sum_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cmps_pkg::POWER_W-1:0]  power
);
  import cmps_pkg::*;

  localparam int TOP_BIT = POWER_SHIFT + POWER_W;

  logic [ACC_W-1:0] mag_re_c, mag_im_c;
  logic [SQ_W:0]    total_c;
  logic             sat_c;

  logic             b_valid_r, c_valid_r, d_valid_r, e_valid_r;
  logic             b_free, c_free, d_free, e_free;
  logic [MAG_W-1:0] b_re_r, b_im_r;
  logic [MAG_W-1:0] re_ll_r, re_lh_r, re_hh_r;
  logic [MAG_W-1:0] im_ll_r, im_lh_r, im_hh_r;
  logic [SQ_W-1:0]  sq_re_r, sq_im_r;
  logic [POWER_W-1:0] power_r;

  always_comb begin
    e_free   = !e_valid_r || out_ready;
    d_free   = !d_valid_r || e_free;
    c_free   = !c_valid_r || d_free;
    b_free   = !b_valid_r || c_free;
    in_ready = b_free;
  end

  always_comb begin
    mag_re_c = sum_re[ACC_W-1] ? ACC_W'(-sum_re) : ACC_W'(sum_re);
    mag_im_c = sum_im[ACC_W-1] ? ACC_W'(-sum_im) : ACC_W'(sum_im);
    total_c  = (SQ_W+1)'(sq_re_r) + (SQ_W+1)'(sq_im_r);
    sat_c    = |total_c[SQ_W:TOP_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      if (b_free) begin
        b_valid_r <= in_valid;
      end
      if (c_free) begin
        c_valid_r <= b_valid_r;
      end
      if (d_free) begin
        d_valid_r <= c_valid_r;
      end
      if (e_free) begin
        e_valid_r <= d_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && b_free) begin
      b_re_r <= MAG_W'(mag_re_c);
      b_im_r <= MAG_W'(mag_im_c);
    end
    // 32x32 partial products of each square
    if (b_valid_r && c_free) begin
      re_ll_r <= b_re_r[HALF_W-1:0]      * b_re_r[HALF_W-1:0];
      re_lh_r <= b_re_r[HALF_W-1:0]      * b_re_r[MAG_W-1:HALF_W];
      re_hh_r <= b_re_r[MAG_W-1:HALF_W]  * b_re_r[MAG_W-1:HALF_W];
      im_ll_r <= b_im_r[HALF_W-1:0]      * b_im_r[HALF_W-1:0];
      im_lh_r <= b_im_r[HALF_W-1:0]      * b_im_r[MAG_W-1:HALF_W];
      im_hh_r <= b_im_r[MAG_W-1:HALF_W]  * b_im_r[MAG_W-1:HALF_W];
    end
    // cross term appears twice, hence the extra shift
    if (c_valid_r && d_free) begin
      sq_re_r <= {re_hh_r, re_ll_r} + (SQ_W'(re_lh_r) << (HALF_W + 1));
      sq_im_r <= {im_hh_r, im_ll_r} + (SQ_W'(im_lh_r) << (HALF_W + 1));
    end
    if (d_valid_r && e_free) begin
      power_r <= sat_c ? '1 : total_c[TOP_BIT-1:POWER_SHIFT];
    end
  end

  assign out_valid = e_valid_r;
  assign power     = power_r;

  a_load_b: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> b_valid_r)
    else $error("sum word lost at magnitude stage");

  a_hold_d: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && !e_free) |=> (d_valid_r && $stable(sq_re_r) && $stable(sq_im_r)))
    else $error("square stage changed while stalled");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && out_ready && !d_valid_r) |=> !e_valid_r)
    else $error("result repeated");

endmodule

/* src/column_mass_power_spectrum_unit.sv */
// column mass power spectrum unit
// in_* stream: one column mass word per transfer, in_tlast marks the last
// column of a run. each mass is weighted by cos and sin of a phase that
// starts at zero and advances by phase_step per column; the complex sums
// are kept in two accumulators; columns past MAX_COLUMNS are not summed.
// out_* stream: one power word per run, produced from the last column:
// (re^2 + im^2) >> 46, saturated to 64 bits.
// cfg_* apb port: register 0 at address 0 is phase_step (16 bits).
// throughput: one column per cycle unless out_tready stalls the pipe;
// the table lookup, the 32x16 multiplies and the accumulate each sit in
// their own stage. after the last column is accepted, the power word
// passes in order through lookup, multiply, accumulate, magnitude,
// partial products, square sum and the output register.
// reset clears the run state, phase_step and all pipeline valids.
// when out_tready is low the power pipe holds its word; bubbles behind it
// still fill, and in_tready drops only once every stage is occupied.
module column_mass_power_spectrum_unit #(
  parameter int MAX_COLUMNS      = cmps_pkg::MAX_COLUMNS_DEF,
  parameter int SINE_TABLE_DEPTH = cmps_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cmps_pkg::MASS_W-1:0]   in_tdata,   // [31:0] cell_mass
  input  logic                          in_tlast,   // last_column
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cmps_pkg::POWER_W-1:0]  out_tdata,  // [63:0] power
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cmps_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [cmps_pkg::CFG_W-1:0]    cfg_pwdata,
  output logic [cmps_pkg::CFG_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import cmps_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(MAX_COLUMNS + 1);

  logic [PHASE_W-1:0]      phase_step_r;
  logic                    cfg_wr;
  logic                    sum_valid, sum_ready;
  logic signed [ACC_W-1:0] sum_re, sum_im;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
    end else if (cfg_wr && cfg_paddr[REG_IDX_BIT] == REG_PHASE_STEP) begin
      phase_step_r <= cfg_pwdata[PHASE_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[REG_IDX_BIT])
      REG_PHASE_STEP: cfg_prdata = CFG_W'(phase_step_r);
      default:        cfg_prdata = '0;
    endcase
  end

  cmps_accum #(
    .MAX_COLUMNS      (MAX_COLUMNS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .ACC_W            (ACC_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (phase_step_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mass    (in_tdata),
    .in_last    (in_tlast),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum_re     (sum_re),
    .sum_im     (sum_im)
  );

  cmps_power #(
    .ACC_W (ACC_W)
  ) u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .sum_re    (sum_re),
    .sum_im    (sum_im),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .power     (out_tdata)
  );

endmodule
